// ----- design/mfd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the market feed message decoder.
// Holds message type codes, result kinds, minimum body lengths, frame phases and the result and control structs.
// No dependencies.
package mfd_pkg;

	localparam int CAPTURE_BYTES_DEF = 44;

	localparam logic [7:0] TYPE_S = 8'h53;
	localparam logic [7:0] TYPE_R = 8'h52;
	localparam logic [7:0] TYPE_A = 8'h41;
	localparam logic [7:0] TYPE_F = 8'h46;
	localparam logic [7:0] TYPE_E = 8'h45;
	localparam logic [7:0] TYPE_C = 8'h43;
	localparam logic [7:0] TYPE_X = 8'h58;
	localparam logic [7:0] TYPE_D = 8'h44;
	localparam logic [7:0] TYPE_U = 8'h55;
	localparam logic [7:0] TYPE_P = 8'h50;

	localparam logic [3:0] KIND_SYSTEM    = 4'd0;
	localparam logic [3:0] KIND_DIRECTORY = 4'd1;
	localparam logic [3:0] KIND_ADD       = 4'd2;
	localparam logic [3:0] KIND_ADD_MPID  = 4'd3;
	localparam logic [3:0] KIND_EXEC      = 4'd4;
	localparam logic [3:0] KIND_EXEC_PX   = 4'd5;
	localparam logic [3:0] KIND_CANCEL    = 4'd6;
	localparam logic [3:0] KIND_DELETE    = 4'd7;
	localparam logic [3:0] KIND_REPLACE   = 4'd8;
	localparam logic [3:0] KIND_TRADE     = 4'd9;
	localparam logic [3:0] KIND_SKIPPED   = 4'd10;

	localparam logic [15:0] NEED_S = 16'd12;
	localparam logic [15:0] NEED_R = 16'd39;
	localparam logic [15:0] NEED_A = 16'd36;
	localparam logic [15:0] NEED_F = 16'd40;
	localparam logic [15:0] NEED_E = 16'd31;
	localparam logic [15:0] NEED_C = 16'd36;
	localparam logic [15:0] NEED_X = 16'd23;
	localparam logic [15:0] NEED_D = 16'd19;
	localparam logic [15:0] NEED_U = 16'd35;
	localparam logic [15:0] NEED_P = 16'd44;

	localparam logic [1:0] PH_LEN_HI = 2'd0;
	localparam logic [1:0] PH_LEN_LO = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	typedef struct packed {
		logic [3:0]  msg_kind;
		logic [15:0] locate_code;
		logic [15:0] track_num;
		logic [47:0] event_ns;
		logic [63:0] ref_primary;
		logic [63:0] ref_secondary;
		logic [31:0] quantity;
		logic [31:0] price;
		logic [7:0]  code_char;
		logic [63:0] symbol;
		logic [31:0] attribution;
	} mfd_res_t;

	// body byte leaving the input register
	typedef struct packed {
		logic wr;    // byte lands in the capture registers
		logic last;  // final body byte of the frame
	} mfd_ctl_t;

endpackage

// ----- design/mfd_frame.sv -----
`timescale 1ns / 1ps
// Frame tracker: length prefix, body byte count and input register.
// Depends on mfd_pkg.
module mfd_frame #(
	parameter int CAPTURE_BYTES = mfd_pkg::CAPTURE_BYTES_DEF,
	parameter int IDX_W = $clog2(CAPTURE_BYTES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 blocked,
	output logic                 wr_en,
	output logic [IDX_W-1:0]     wr_idx,
	output logic [7:0]           wr_data,
	output logic                 req,
	output logic [15:0]          req_len
);
	import mfd_pkg::*;

	logic [1:0]       phase_q;
	logic [15:0]      len_q;
	logic [15:0]      count_q;
	logic             valid_s1;
	mfd_ctl_t         ctl_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [7:0]       byte_s1;
	logic [15:0]      len_s1;
	logic             accept;
	logic             advance;
	logic [16:0]      count_inc;
	logic [15:0]      len_full;

	assign advance   = valid_s1 && !blocked;
	assign s_tready  = !(valid_s1 && blocked);
	assign accept    = s_tvalid && s_tready;
	assign count_inc = {1'b0, count_q} + 17'd1;
	assign len_full  = {len_q[15:8], s_tdata};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN_HI;
			len_q    <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance)
				valid_s1 <= 1'b0;
			if (accept) begin
				unique case (phase_q)
					PH_LEN_LO: begin
						len_q   <= len_full;
						count_q <= '0;
						phase_q <= (len_full == 16'd0) ? PH_LEN_HI : PH_BODY;
					end
					PH_BODY: begin
						valid_s1 <= 1'b1;
						if (count_inc >= {1'b0, len_q}) begin
							count_q <= '0;
							phase_q <= PH_LEN_HI;
						end else begin
							count_q <= count_inc[15:0];
						end
					end
					default: begin
						len_q   <= {s_tdata, 8'h00};
						count_q <= '0;
						phase_q <= PH_LEN_LO;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_BODY) begin
			byte_s1     <= s_tdata;
			idx_s1      <= count_q[IDX_W-1:0];
			ctl_s1.wr   <= count_q < 16'(CAPTURE_BYTES);
			ctl_s1.last <= count_inc >= {1'b0, len_q};
			len_s1      <= len_q;
		end
	end

	assign wr_en   = advance && ctl_s1.wr;
	assign wr_idx  = idx_s1;
	assign wr_data = byte_s1;
	assign req     = advance && ctl_s1.last;
	assign req_len = len_s1;

endmodule

// ----- design/mfd_capture.sv -----
`timescale 1ns / 1ps
// Capture registers for the leading body bytes of the current frame.
// Depends on nothing beyond its parameters.
module mfd_capture #(
	parameter int CAPTURE_BYTES = 44,
	parameter int IDX_W = $clog2(CAPTURE_BYTES)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [7:0]       wr_data,
	output logic [7:0]       body [CAPTURE_BYTES]
);

	logic [7:0] body_q [CAPTURE_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en)
			body_q[wr_idx] <= wr_data;
	end

	assign body = body_q;

endmodule

// ----- design/mfd_decode.sv -----
`timescale 1ns / 1ps
// Field decoder and result register.
// Depends on mfd_pkg; reads the capture registers once the last body byte has been written into them.
module mfd_decode #(
	parameter int CAPTURE_BYTES = mfd_pkg::CAPTURE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req,
	input  logic [15:0]         req_len,
	input  logic [7:0]          body [CAPTURE_BYTES],
	output logic                blocked,
	output logic                out_valid,
	input  logic                out_ready,
	output mfd_pkg::mfd_res_t   out_res
);
	import mfd_pkg::*;

	logic      pend_s2;
	logic [15:0] len_s2;
	logic      out_valid_q;
	mfd_res_t  res_q;
	mfd_res_t  res;
	logic [3:0]  kind;
	logic [15:0] need;
	logic        known;
	logic        move;

	assign blocked = pend_s2 && out_valid_q && !out_ready;
	assign move    = pend_s2 && !blocked;

	always_comb begin
		known = 1'b1;
		kind  = KIND_SKIPPED;
		need  = '0;
		unique case (body[0])
			TYPE_S: begin kind = KIND_SYSTEM;    need = NEED_S; end
			TYPE_R: begin kind = KIND_DIRECTORY; need = NEED_R; end
			TYPE_A: begin kind = KIND_ADD;       need = NEED_A; end
			TYPE_F: begin kind = KIND_ADD_MPID;  need = NEED_F; end
			TYPE_E: begin kind = KIND_EXEC;      need = NEED_E; end
			TYPE_C: begin kind = KIND_EXEC_PX;   need = NEED_C; end
			TYPE_X: begin kind = KIND_CANCEL;    need = NEED_X; end
			TYPE_D: begin kind = KIND_DELETE;    need = NEED_D; end
			TYPE_U: begin kind = KIND_REPLACE;   need = NEED_U; end
			TYPE_P: begin kind = KIND_TRADE;     need = NEED_P; end
			default: known = 1'b0;
		endcase
	end

	always_comb begin
		res = '0;
		if (!known || len_s2 < need) begin
			res.msg_kind = KIND_SKIPPED;
		end else begin
			res.msg_kind    = kind;
			res.locate_code = {body[1], body[2]};
			res.track_num   = {body[3], body[4]};
			res.event_ns    = {body[5], body[6], body[7], body[8], body[9], body[10]};
			case (kind)
				KIND_SYSTEM: res.code_char = body[11];
				KIND_DIRECTORY: begin
					res.symbol        = {body[11], body[12], body[13], body[14],
					                     body[15], body[16], body[17], body[18]};
					res.ref_primary   = {body[19], body[20], body[25], body[26],
					                     body[27], body[28], body[29], body[30]};
					res.ref_secondary = {40'd0, body[31], body[32], body[33]};
					res.quantity      = {body[21], body[22], body[23], body[24]};
					res.price         = {body[34], body[35], body[36], body[37]};
					res.code_char     = body[38];
				end
				KIND_ADD, KIND_ADD_MPID, KIND_TRADE: begin
					res.ref_primary = {body[11], body[12], body[13], body[14],
					                   body[15], body[16], body[17], body[18]};
					res.code_char   = body[19];
					res.quantity    = {body[20], body[21], body[22], body[23]};
					res.symbol      = {body[24], body[25], body[26], body[27],
					                   body[28], body[29], body[30], body[31]};
					res.price       = {body[32], body[33], body[34], body[35]};
					if (kind == KIND_ADD_MPID)
						res.attribution = {body[36], body[37], body[38], body[39]};
					if (kind == KIND_TRADE)
						res.ref_secondary = {body[36], body[37], body[38], body[39],
						                     body[40], body[41], body[42], body[43]};
				end
				KIND_EXEC, KIND_EXEC_PX: begin
					res.ref_primary   = {body[11], body[12], body[13], body[14],
					                     body[15], body[16], body[17], body[18]};
					res.quantity      = {body[19], body[20], body[21], body[22]};
					res.ref_secondary = {body[23], body[24], body[25], body[26],
					                     body[27], body[28], body[29], body[30]};
					if (kind == KIND_EXEC_PX) begin
						res.code_char = body[31];
						res.price     = {body[32], body[33], body[34], body[35]};
					end
				end
				KIND_CANCEL: begin
					res.ref_primary = {body[11], body[12], body[13], body[14],
					                   body[15], body[16], body[17], body[18]};
					res.quantity    = {body[19], body[20], body[21], body[22]};
				end
				KIND_DELETE: begin
					res.ref_primary = {body[11], body[12], body[13], body[14],
					                   body[15], body[16], body[17], body[18]};
				end
				default: begin
					// replace
					res.ref_primary   = {body[11], body[12], body[13], body[14],
					                     body[15], body[16], body[17], body[18]};
					res.ref_secondary = {body[19], body[20], body[21], body[22],
					                     body[23], body[24], body[25], body[26]};
					res.quantity      = {body[27], body[28], body[29], body[30]};
					res.price         = {body[31], body[32], body[33], body[34]};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req)
				pend_s2 <= 1'b1;
			else if (move)
				pend_s2 <= 1'b0;
			if (move)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req)
			len_s2 <= req_len;
		if (move)
			res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

// ----- design/market_feed_message_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the market feed message decoder.
// Depends on mfd_pkg, mfd_frame, mfd_capture and mfd_decode.
//
// Takes one stream byte per cycle: a 16-bit big-endian frame length, then that many body
// bytes. One result per non-empty frame is presented once its last body byte has passed
// the input register, the capture write and the decode into the result register. Line rate
// is one byte per cycle; the input stalls only when a decoded frame is waiting behind a
// result that has not been taken. Short bodies and unknown types give msg_kind skipped with
// all other fields zero; bytes past CAPTURE_BYTES are dropped. m_tuser carries msg_kind.
module market_feed_message_decoder #(
	parameter int CAPTURE_BYTES = mfd_pkg::CAPTURE_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] locate_code, [31:16] track_num, [79:32] event_ns,
	// [143:80] ref_primary, [207:144] ref_secondary, [239:208] quantity,
	// [271:240] price, [279:272] code_char, [343:280] symbol, [375:344] attribution
	output logic [375:0] m_tdata,
	output logic [3:0]   m_tuser    // [3:0] msg_kind
);
	import mfd_pkg::*;

	localparam int IDX_W = $clog2(CAPTURE_BYTES);

	logic             blocked;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       wr_data;
	logic             req;
	logic [15:0]      req_len;
	logic [7:0]       body [CAPTURE_BYTES];
	mfd_res_t         res;

	mfd_frame #(.CAPTURE_BYTES(CAPTURE_BYTES), .IDX_W(IDX_W)) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.blocked  (blocked),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data),
		.req      (req),
		.req_len  (req_len)
	);

	mfd_capture #(.CAPTURE_BYTES(CAPTURE_BYTES), .IDX_W(IDX_W)) u_capture (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.body    (body)
	);

	mfd_decode #(.CAPTURE_BYTES(CAPTURE_BYTES)) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_len   (req_len),
		.body      (body),
		.blocked   (blocked),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tuser = res.msg_kind;
	assign m_tdata = {res.attribution, res.symbol, res.code_char, res.price, res.quantity,
	                  res.ref_secondary, res.ref_primary, res.event_ns,
	                  res.track_num, res.locate_code};

`ifndef NO_ASSERTIONS
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= KIND_SKIPPED)
		else $error("result kind out of range");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_SKIPPED) |-> m_tdata == '0)
		else $error("skipped result carries data");

	a_attr_mpid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_ADD_MPID) |-> m_tdata[375:344] == '0)
		else $error("attribution outside add mpid");

	a_no_write_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		blocked |-> !wr_en && !req)
		else $error("capture written while decode is stalled");
`endif

endmodule
